@@ rtl/rks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rks_pkg: shared types and constants for the range k-th smallest block
// Field widths of the request and result streams, request kinds and the
// lane organization of the value memory.
// ----------------------------------------------------------------------------
package rks_pkg;

  // Request and result field widths.
  localparam int IDX_BITS   = 10;
  localparam int VAL_BITS   = 30;
  localparam int RANK_BITS  = 11;
  localparam int LEN_BITS   = 11;

  // Request tdata layout, lowest bit first.
  localparam int LEFT_LSB   = 0;
  localparam int RIGHT_LSB  = LEFT_LSB + IDX_BITS;
  localparam int NVAL_LSB   = RIGHT_LSB + IDX_BITS;
  localparam int RANK_LSB   = NVAL_LSB + VAL_BITS;
  localparam int IN_BITS    = RANK_LSB + RANK_BITS;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_BITS + 7) / 8) * 8;

  // Each memory row holds this many neighboring entries.
  localparam int LANES      = 8;
  localparam int LANE_BITS  = 3;
  localparam int POP_BITS   = 4;

  // Request kinds carried on tuser.
  typedef enum logic {
    FUNC_UPDATE = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

endpackage

@@ rtl/range_kth_smallest_with_updates.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_kth_smallest_with_updates: k-th smallest value over an index range
// Holds an array of unsigned values that requests update one entry at a time
// and answers rank queries over an inclusive index range.
// ----------------------------------------------------------------------------
// Usage. Requests enter on the s_axis group. tuser selects the kind: an
// update writes new_value to entry left_index and returns nothing; a query
// returns one result on the m_axis group holding the rank-th smallest value
// of entries left_index through right_index, or an error flag on tuser with
// zero data when the range or the rank is bad. cfg_wr_en/cfg_wr_data set the
// number of entries in use; write it only while the block is idle.
//
// Timing. A query builds its answer one bit at a time from the top: each of
// the VALUE_BITS passes streams the memory rows that cover the range, eight
// entries per row and one row per cycle, then drains its compare and count
// pipeline (memory read register, hit register, count) before it decides
// the bit. A bad query skips the passes and goes straight to the finish
// step. One request is worked on at a time.
//
// Reset. The synchronous reset starts a clearing pass that zeroes the value
// memory one row per cycle over all (DEPTH + 7) / 8 rows (128 at the default
// size); s_axis_tready stays low until it ends. Configuration writes are
// taken during the pass. A finished result waits in the output register
// while m_axis_tready is low, and the block still accepts the next request;
// a second result waits inside the block until the register frees up.
// ----------------------------------------------------------------------------
module range_kth_smallest_with_updates #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 30
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: length_in_use.
  input  logic                            cfg_wr_en,
  input  logic [rks_pkg::LEN_BITS-1:0]    cfg_wr_data,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, from bit 0: left_index[9:0], right_index[9:0], new_value[29:0],
  // rank[10:0], three zero pad bits.
  input  logic [rks_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func (0 = update, 1 = query).
  input  logic                            s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, from bit 0: kth_value[29:0], two zero pad bits.
  output logic [rks_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: error.
  output logic                            m_axis_tuser
);

  import rks_pkg::*;

  localparam int ROWS = (DEPTH + LANES - 1) / LANES;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BW   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS,
    ST_WAIT,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [LEN_BITS-1:0]    length_in_use;

  // Request fields.
  logic [IDX_BITS-1:0]    in_left;
  logic [IDX_BITS-1:0]    in_right;
  logic [VAL_BITS-1:0]    in_value;
  logic [RANK_BITS-1:0]   in_rank;
  logic [LEN_BITS-1:0]    len_eff;
  logic [RANK_BITS-1:0]   in_span;
  logic                   in_bad;
  logic                   accept;

  // Query context.
  logic [IDX_BITS-1:0]    left_q;
  logic [IDX_BITS-1:0]    right_q;
  logic [RANK_BITS-1:0]   rank_q;
  logic [RANK_BITS-1:0]   span_q;
  logic [RAW-1:0]         row_lo;
  logic [RAW-1:0]         row_hi;
  logic [RAW-1:0]         rd_row;
  logic [RAW-1:0]         clr_row;
  logic [BW-1:0]          bitn;
  logic [VALUE_BITS-1:0]  ans;
  logic [VALUE_BITS-1:0]  trial;
  logic [RANK_BITS-1:0]   count;
  logic                   err_q;

  // Memory ports and the compare pipeline.
  logic [LANES-1:0][VALUE_BITS-1:0] mem [ROWS];
  logic [LANES-1:0][VALUE_BITS-1:0] rd_data;
  logic                   rd_issue;
  logic                   v1;
  logic                   v2;
  logic [RAW-1:0]         row1;
  logic [LANES-1:0]       hit_d;
  logic [LANES-1:0]       hits;
  logic [POP_BITS-1:0]    pop;
  logic                   wr_en;
  logic [RAW-1:0]         wr_row;
  logic [LANES-1:0]       wr_lanes;
  logic [VALUE_BITS-1:0]  wr_val;

  assign in_left  = s_axis_tdata[LEFT_LSB +: IDX_BITS];
  assign in_right = s_axis_tdata[RIGHT_LSB +: IDX_BITS];
  assign in_value = s_axis_tdata[NVAL_LSB +: VAL_BITS];
  assign in_rank  = s_axis_tdata[RANK_LSB +: RANK_BITS];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The usable length is the smaller of the register and the memory depth.
  assign len_eff = (32'(length_in_use) < DEPTH) ? length_in_use : LEN_BITS'(DEPTH);
  assign in_span = RANK_BITS'(in_right) - RANK_BITS'(in_left) + RANK_BITS'(1);
  assign in_bad  = (in_left > in_right) || (LEN_BITS'(in_right) >= len_eff) ||
                   (in_rank == '0) || (in_rank > in_span);

  // Trial value of the current pass: answer so far with the current bit set.
  assign trial    = ans | (VALUE_BITS'(1) << bitn);
  assign rd_issue = (state == ST_PASS);

  // One write port shared by the clearing pass and updates.
  always_comb begin
    wr_en    = 1'b0;
    wr_row   = clr_row;
    wr_lanes = '1;
    wr_val   = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (accept && (s_axis_tuser == FUNC_UPDATE) &&
                 (LEN_BITS'(in_left) < len_eff)) begin
      wr_en    = 1'b1;
      wr_row   = RAW'(in_left >> LANE_BITS);
      wr_lanes = LANES'(1) << in_left[LANE_BITS-1:0];
      wr_val   = VALUE_BITS'(in_value);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int ln = 0; ln < LANES; ln++) begin
        if (wr_lanes[ln]) begin
          mem[wr_row][ln] <= wr_val;
        end
      end
    end
    if (rd_issue) begin
      rd_data <= mem[rd_row];
    end
  end

  // Lanes of the returned row that lie in the range and below the trial.
  always_comb begin
    for (int ln = 0; ln < LANES; ln++) begin
      hit_d[ln] = ((row1 != row_lo) || (LANE_BITS'(ln) >= left_q[LANE_BITS-1:0])) &&
                  ((row1 != row_hi) || (LANE_BITS'(ln) <= right_q[LANE_BITS-1:0])) &&
                  (rd_data[ln] < trial);
    end
  end

  always_comb begin
    pop = '0;
    for (int ln = 0; ln < LANES; ln++) begin
      pop = pop + POP_BITS'(hits[ln]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_row       <= '0;
      length_in_use <= LEN_BITS'(1024);
      v1            <= 1'b0;
      v2            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        length_in_use <= cfg_wr_data;
      end
      // The finish step reloads the register itself in the same cycle.
      if (m_axis_tvalid && m_axis_tready && (state != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end

      v1   <= rd_issue;
      row1 <= rd_row;
      v2   <= v1;
      hits <= hit_d;
      if (v2) begin
        count <= count + RANK_BITS'(pop);
      end

      unique case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + RAW'(1);
          if (clr_row == RAW'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (s_axis_tuser == FUNC_QUERY)) begin
            left_q  <= in_left;
            right_q <= in_right;
            rank_q  <= in_rank;
            span_q  <= in_span;
            row_lo  <= RAW'(in_left >> LANE_BITS);
            row_hi  <= RAW'(in_right >> LANE_BITS);
            rd_row  <= RAW'(in_left >> LANE_BITS);
            bitn    <= BW'(VALUE_BITS - 1);
            ans     <= '0;
            count   <= '0;
            err_q   <= in_bad;
            state   <= in_bad ? ST_FINISH : ST_PASS;
          end
        end
        ST_PASS: begin
          if (rd_row == row_hi) begin
            state <= ST_WAIT;
          end else begin
            rd_row <= rd_row + RAW'(1);
          end
        end
        ST_WAIT: begin
          // All rows of the pass are counted once the pipeline is empty.
          if (!v1 && !v2) begin
            if (count < rank_q) begin
              ans <= trial;
            end
            count  <= '0;
            rd_row <= row_lo;
            if (bitn == '0) begin
              state <= ST_FINISH;
            end else begin
              bitn  <= bitn - BW'(1);
              state <= ST_PASS;
            end
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_TDATA_W'(err_q ? '0 : VAL_BITS'(ans));
            m_axis_tuser  <= err_q;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A counted row must have been read the cycle before.
  assert property (@(posedge clk) disable iff (rst) v2 |-> $past(v1))
    else $error("count stage active without a memory read");

  // Entries below the trial can never outnumber the range.
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_PASS) || (state == ST_WAIT)) |-> (count <= span_q))
    else $error("count exceeds range length");

  // Results only come out of the finish step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside finish");

  // An error result carries zero data.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error result with nonzero value");

  // No request is taken while the memory is being cleared.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> ((state == ST_CLEAR) || (state == ST_IDLE)))
    else $error("clearing pass left early");

endmodule
